// ===== rtl/epcb_pkg.sv =====
package epcb_pkg;

  localparam int CNT_W   = 64;
  localparam int DEPTH_W = 32;

  typedef enum logic [1:0] {
    MODE_RECORD      = 2'd0,
    MODE_READ_EVENT  = 2'd1,
    MODE_READ_OPCODE = 2'd2,
    MODE_CLEAR       = 2'd3
  } mode_t;

  // Result of one saturating increment.
  typedef struct packed {
    logic [CNT_W-1:0] value;
    logic             hit_max;
  } inc_result_t;

endpackage

// ===== rtl/epcb_ram.sv =====
module epcb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/epcb_sat_inc.sv =====
module epcb_sat_inc (
  input  logic [epcb_pkg::CNT_W-1:0] cur,
  output epcb_pkg::inc_result_t      res
);

  // Hold at all ones and flag it; otherwise advance by one.
  always_comb begin
    res.hit_max = &cur;
    res.value   = res.hit_max ? cur : cur + epcb_pkg::CNT_W'(1);
  end

endmodule

// ===== rtl/event_profile_counter_bank_core.sv =====
// Channel | Dir | tdata (low bit up)                                      | tuser
// s_*     | in  | event_kind[3:0] opcode[11:4] call_depth[43:12]            | mode[1:0]
//         |     | read_index[51:44], zero pad [55:52]                      |
// m_*     | out | count_value[63:0] max_depth[95:64]                       | saturated_flag[0]
//
// The accept cycle issues the counter memory reads; the execute state then
// modifies and writes back or loads the result register. A read beat waits
// in the execute state while an earlier result is still held on m_*. Reset
// and a clear beat empty the bank through per-entry valid flops; there is no
// clearing pass. Record and clear beats produce no output beat.
module event_profile_counter_bank_core #(
  parameter int NUM_EVENT_KINDS  = 8,
  parameter int NUM_OPCODES      = 256,
  parameter int INSTRUCTION_KIND = 0,
  parameter int INVALID_OPCODE   = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // event_kind, opcode, call_depth, read_index
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // count_value, max_depth
  output logic [0:0]  m_tuser    // saturated_flag
);

  localparam int CW   = epcb_pkg::CNT_W;
  localparam int DW   = epcb_pkg::DEPTH_W;
  localparam int EV_AW = (NUM_EVENT_KINDS > 1) ? $clog2(NUM_EVENT_KINDS) : 1;
  localparam int OP_AW = (NUM_OPCODES > 1) ? $clog2(NUM_OPCODES) : 1;

  localparam logic [4:0] NUM_EV_L  = 5'(NUM_EVENT_KINDS);
  localparam logic [8:0] NUM_OP_L  = 9'(NUM_OPCODES);
  localparam logic [3:0] INSTR_L   = 4'(INSTRUCTION_KIND);
  localparam logic [7:0] INVALID_L = 8'(INVALID_OPCODE);

  typedef enum logic {ST_IDLE, ST_EXEC} st_t;

  st_t state;

  // Input beat fields.
  epcb_pkg::mode_t in_mode;
  logic [3:0]      in_kind;
  logic [7:0]      in_op;
  logic [DW-1:0]   in_depth;
  logic [7:0]      in_idx;
  logic            accept;

  assign in_mode  = epcb_pkg::mode_t'(s_tuser);
  assign in_kind  = s_tdata[3:0];
  assign in_op    = s_tdata[11:4];
  assign in_depth = s_tdata[43:12];
  assign in_idx   = s_tdata[51:44];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Captured beat.
  epcb_pkg::mode_t mode_q;
  logic [3:0]      kind_q;
  logic [7:0]      op_q;
  logic [DW-1:0]   depth_q;
  logic [7:0]      idx_q;
  logic [EV_AW-1:0] ev_addr_q;
  logic [OP_AW-1:0] op_addr_q;

  // Bank state outside the memories.
  logic [(2**EV_AW)-1:0] ev_valid;
  logic [(2**OP_AW)-1:0] op_valid;
  logic                  sticky;
  logic [DW-1:0]         deepest;

  // Read addresses: a record beat reads its kind and opcode entries, a read
  // beat reads the selected entry.
  logic [EV_AW-1:0] ev_raddr;
  logic [OP_AW-1:0] op_raddr;

  always_comb begin
    ev_raddr = in_kind[EV_AW-1:0];
    op_raddr = in_op[OP_AW-1:0];
    if (in_mode == epcb_pkg::MODE_READ_EVENT) begin
      ev_raddr = in_idx[EV_AW-1:0];
    end
    if (in_mode == epcb_pkg::MODE_READ_OPCODE) begin
      op_raddr = in_idx[OP_AW-1:0];
    end
  end

  logic [CW-1:0] ev_rdata, op_rdata, ev_cur, op_cur;
  logic          ev_we, op_we;
  epcb_pkg::inc_result_t ev_inc, op_inc;

  epcb_ram #(.WIDTH(CW), .DEPTH(NUM_EVENT_KINDS)) u_ev_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_addr_q),
    .wdata (ev_inc.value),
    .re    (accept),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  epcb_ram #(.WIDTH(CW), .DEPTH(NUM_OPCODES)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_addr_q),
    .wdata (op_inc.value),
    .re    (accept),
    .raddr (op_raddr),
    .rdata (op_rdata)
  );

  // An entry not written since the last clear reads as zero.
  assign ev_cur = ev_valid[ev_addr_q] ? ev_rdata : '0;
  assign op_cur = op_valid[op_addr_q] ? op_rdata : '0;

  epcb_sat_inc u_ev_inc (.cur(ev_cur), .res(ev_inc));
  epcb_sat_inc u_op_inc (.cur(op_cur), .res(op_inc));

  logic kind_ok, op_ok, ev_idx_ok, op_idx_ok, is_read, done;

  assign kind_ok   = {1'b0, kind_q} < NUM_EV_L;
  assign op_ok     = (kind_q == INSTR_L) && (op_q > INVALID_L) && ({1'b0, op_q} < NUM_OP_L);
  assign ev_idx_ok = {1'b0, idx_q} < {4'd0, NUM_EV_L};
  assign op_idx_ok = {1'b0, idx_q} < NUM_OP_L;
  assign is_read   = (mode_q == epcb_pkg::MODE_READ_EVENT) ||
                     (mode_q == epcb_pkg::MODE_READ_OPCODE);
  // Hold a read beat while the previous result is still waiting.
  assign done      = (state == ST_EXEC) && (!is_read || !m_tvalid || m_tready);

  assign ev_we = done && (mode_q == epcb_pkg::MODE_RECORD) && kind_ok;
  assign op_we = ev_we && op_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      ev_valid <= '0;
      op_valid <= '0;
      sticky   <= 1'b0;
      deepest  <= '0;
    end else begin
      // Drop the held result once taken, unless a new one replaces it now.
      if (m_tvalid && m_tready && !(done && is_read)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state <= ST_IDLE;
            case (mode_q)
              epcb_pkg::MODE_RECORD: begin
                if (kind_ok) begin
                  ev_valid[ev_addr_q] <= 1'b1;
                  if (ev_inc.hit_max || (op_ok && op_inc.hit_max)) begin
                    sticky <= 1'b1;
                  end
                  if (op_ok) begin
                    op_valid[op_addr_q] <= 1'b1;
                  end
                  if (depth_q > deepest) begin
                    deepest <= depth_q;
                  end
                end
              end
              epcb_pkg::MODE_CLEAR: begin
                ev_valid <= '0;
                op_valid <= '0;
                sticky   <= 1'b0;
                deepest  <= '0;
              end
              default: begin
                m_tvalid <= 1'b1;
              end
            endcase
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: captured beat and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q    <= in_mode;
      kind_q    <= in_kind;
      op_q      <= in_op;
      depth_q   <= in_depth;
      idx_q     <= in_idx;
      ev_addr_q <= ev_raddr;
      op_addr_q <= op_raddr;
    end
    if (done && is_read) begin
      if (mode_q == epcb_pkg::MODE_READ_EVENT) begin
        m_tdata[CW-1:0] <= ev_idx_ok ? ev_cur : '0;
      end else begin
        m_tdata[CW-1:0] <= op_idx_ok ? op_cur : '0;
      end
      m_tdata[95:CW] <= deepest;
      m_tuser[0]     <= sticky;
    end
  end

  // An accepted beat blocks the input in the cycle after it is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a beat is in progress");

  // A finished clear leaves flag and depth at zero.
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (done && mode_q == epcb_pkg::MODE_CLEAR) |=> (!sticky && deepest == '0))
    else $error("clear left flag or depth set");

  // The deepest frame only grows between clears.
  a_depth_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(done && mode_q == epcb_pkg::MODE_CLEAR) |=> (deepest >= $past(deepest)))
    else $error("deepest frame decreased without clear");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Bank geometry, matching the instance below.
  localparam int NUM_KINDS   = 8;
  localparam int NUM_OPS     = 256;
  localparam int INSTR_KIND  = 0;
  localparam int NO_OPCODE   = 0;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic [epcb_pkg::CNT_W-1:0]   count;
    logic                         sat;
    logic [epcb_pkg::DEPTH_W-1:0] depth;
  } profile_read_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = epcb_pkg::MODE_RECORD;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [0:0]  m_tuser;

  // Shadow copy of the bank state.
  logic [epcb_pkg::CNT_W-1:0]   kind_count [NUM_KINDS];
  logic [epcb_pkg::CNT_W-1:0]   op_count [NUM_OPS];
  logic                         sat_sticky;
  logic [epcb_pkg::DEPTH_W-1:0] deepest_seen;

  profile_read_t pending_reads[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int reads_checked = 0;
  int records_sent = 0;
  int clears_sent = 0;
  int beats_sent = 0;
  int cycle_count = 0;

  event_profile_counter_bank_core #(
    .NUM_EVENT_KINDS (NUM_KINDS),
    .NUM_OPCODES     (NUM_OPS),
    .INSTRUCTION_KIND(INSTR_KIND),
    .INVALID_OPCODE  (NO_OPCODE)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Saturating increment; a counter already at all ones holds and sets the sticky flag.
  // A 64-bit counter cannot be walked to its maximum in a run of this length, so this
  // path stays in the model without being exercised.
  function automatic logic [epcb_pkg::CNT_W-1:0] bumped(
      input logic [epcb_pkg::CNT_W-1:0] c);
    if (&c) begin
      sat_sticky = 1'b1;
      return c;
    end
    return c + 1'b1;
  endfunction

  function automatic void clear_bank();
    foreach (kind_count[i]) kind_count[i] = '0;
    foreach (op_count[i]) op_count[i] = '0;
    sat_sticky = 1'b0;
    deepest_seen = '0;
  endfunction

  // Update the shadow bank for one accepted beat and queue the read-back it causes.
  function automatic void profile_update(input epcb_pkg::mode_t m, input logic [3:0] kind,
                                         input logic [7:0] op, input logic [31:0] depth,
                                         input logic [7:0] idx);
    profile_read_t rd;
    case (m)
      epcb_pkg::MODE_RECORD: begin
        records_sent++;
        if (kind < NUM_KINDS) begin
          kind_count[kind] = bumped(kind_count[kind]);
          if (kind == INSTR_KIND && op > NO_OPCODE && op < NUM_OPS)
            op_count[op] = bumped(op_count[op]);
          if (depth > deepest_seen) deepest_seen = depth;
        end
      end
      epcb_pkg::MODE_CLEAR: begin
        clears_sent++;
        clear_bank();
      end
      default: begin
        rd.count = '0;
        if (m == epcb_pkg::MODE_READ_EVENT) begin
          if (idx < NUM_KINDS) rd.count = kind_count[idx];
        end else begin
          if (idx < NUM_OPS) rd.count = op_count[idx];
        end
        rd.sat = sat_sticky;
        rd.depth = deepest_seen;
        pending_reads.push_back(rd);
      end
    endcase
  endfunction

  // Present one beat, idling first at the current sender rate, and hold it until taken.
  task automatic send_beat(input epcb_pkg::mode_t m, input logic [3:0] kind,
                           input logic [7:0] op, input logic [31:0] depth,
                           input logic [7:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, idx, depth, op, kind};
    s_tuser <= m;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    profile_update(m, kind, op, depth, idx);
  endtask

  task automatic test_record_extremes();
    // Opcode zero is the invalid opcode: only the kind counter moves.
    send_beat(epcb_pkg::MODE_RECORD, 4'd0, 8'd0, 32'd0, 8'd0);
    send_beat(epcb_pkg::MODE_RECORD, 4'd0, 8'd255, 32'd1, 8'hFF);
    send_beat(epcb_pkg::MODE_RECORD, 4'd0, 8'd1, 32'hFFFF_FFFE, 8'd0);
    send_beat(epcb_pkg::MODE_RECORD, 4'd7, 8'hAA, 32'hFFFF_FFFF, 8'h55);
    // Non-instruction kind with a valid opcode must not touch the opcode bank.
    send_beat(epcb_pkg::MODE_RECORD, 4'd3, 8'd255, 32'd0, 8'd0);
  endtask

  task automatic test_read_range();
    send_beat(epcb_pkg::MODE_READ_EVENT, 4'hF, 8'hFF, 32'hFFFF_FFFF, 8'd0);
    send_beat(epcb_pkg::MODE_READ_EVENT, 4'd0, 8'd0, 32'd0, 8'd3);
    send_beat(epcb_pkg::MODE_READ_EVENT, 4'd0, 8'd0, 32'd0, 8'd7);
    // Indexes past the last kind read back zero.
    send_beat(epcb_pkg::MODE_READ_EVENT, 4'd0, 8'd0, 32'd0, 8'd8);
    send_beat(epcb_pkg::MODE_READ_EVENT, 4'd0, 8'd0, 32'd0, 8'd255);
    send_beat(epcb_pkg::MODE_READ_OPCODE, 4'd0, 8'd0, 32'd0, 8'd0);
    send_beat(epcb_pkg::MODE_READ_OPCODE, 4'd0, 8'd0, 32'd0, 8'd1);
    send_beat(epcb_pkg::MODE_READ_OPCODE, 4'd0, 8'd0, 32'd0, 8'd255);
  endtask

  task automatic test_ignored_kinds();
    send_beat(epcb_pkg::MODE_CLEAR, 4'hF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    // Out-of-range kinds leave everything alone, including the deepest frame.
    send_beat(epcb_pkg::MODE_RECORD, 4'd8, 8'd1, 32'hFFFF_FFFF, 8'd0);
    send_beat(epcb_pkg::MODE_RECORD, 4'd15, 8'd255, 32'h8000_0000, 8'd0);
    send_beat(epcb_pkg::MODE_READ_EVENT, 4'd0, 8'd0, 32'd0, 8'd0);
    send_beat(epcb_pkg::MODE_READ_OPCODE, 4'd0, 8'd0, 32'd0, 8'd255);
  endtask

  // Mostly records and reads aimed at a handful of live counters, with the full field
  // ranges mixed in and an occasional clear.
  task automatic test_random_traffic(input int beats);
    int          pick;
    logic [3:0]  kind;
    logic [7:0]  op;
    logic [31:0] depth;
    logic [7:0]  idx;
    for (int n = 0; n < beats; n++) begin
      pick  = $urandom_range(99);
      kind  = 4'($urandom);
      op    = 8'($urandom);
      depth = $urandom;
      idx   = 8'($urandom);
      if (pick < 55) begin
        if ($urandom_range(9) != 0)
          kind = ($urandom_range(2) == 0) ? 4'($urandom_range(NUM_KINDS - 1))
                                          : 4'(INSTR_KIND);
        if ($urandom_range(3) != 0)
          op = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(7));
        if ($urandom_range(1) == 0) depth = $urandom_range(1000);
        send_beat(epcb_pkg::MODE_RECORD, kind, op, depth, idx);
      end else if (pick < 76) begin
        if ($urandom_range(4) != 0) idx = 8'($urandom_range(9));
        send_beat(epcb_pkg::MODE_READ_EVENT, kind, op, depth, idx);
      end else if (pick < 97) begin
        if ($urandom_range(4) != 0)
          idx = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(7));
        send_beat(epcb_pkg::MODE_READ_OPCODE, kind, op, depth, idx);
      end else begin
        send_beat(epcb_pkg::MODE_CLEAR, kind, op, depth, idx);
      end
    end
  endtask

  // Result receiver: stall at the current rate.
  initial begin
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each delivered beat with the oldest outstanding read.
  always @(posedge clk) begin
    profile_read_t exp_rd;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reads.size() == 0) begin
        $error("result beat with no read outstanding: tdata=%h tuser=%b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        exp_rd = pending_reads.pop_front();
        reads_checked++;
        if (m_tdata[63:0] !== exp_rd.count) begin
          $error("count_value: expected %0d, got %0d", exp_rd.count, m_tdata[63:0]);
          mismatches++;
        end
        if (m_tuser[0] !== exp_rd.sat) begin
          $error("saturated_flag: expected %0b, got %0b", exp_rd.sat, m_tuser[0]);
          mismatches++;
        end
        if (m_tdata[95:64] !== exp_rd.depth) begin
          $error("max_depth: expected %0d, got %0d", exp_rd.depth, m_tdata[95:64]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d reads outstanding", cycle_count,
             pending_reads.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int idle_plan[4]  = '{0, 69, 0, 30};
    int stall_plan[4] = '{0, 0, 69, 30};
    clear_bank();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_record_extremes();
    test_read_range();
    test_ignored_kinds();
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      test_random_traffic(190);
    end

    s_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d beats: %0d records, %0d clears, %0d reads checked field by field,",
             beats_sent, records_sent, clears_sent, reads_checked);
    $display("under no pacing, sender gaps, receiver stalls and both together.");
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/epcb_pkg.sv
rtl/epcb_ram.sv
rtl/epcb_sat_inc.sv
rtl/event_profile_counter_bank_core.sv
bench/tb_top.sv
